FILE: src/vft_pkg.sv
// Shared types and constants of the four-state Viterbi tagger.
// Used by the register block, controller, datapath and top level.
// No dependencies.
package vft_pkg;

	// defaults for the top-level parameters
	localparam int MAX_LEN_DEF     = 64;
	localparam int SCORE_WIDTH_DEF = 16;

	localparam int NSTATE  = 4;
	// widest candidate sum: 32-bit path + two 16-bit operands
	localparam int ACC_W   = 34;
	localparam int SCORE_W = 32;

	// -99999.0 in Q8.8, the starting point of every compare
	localparam logic signed [ACC_W-1:0] SCORE_FLOOR = -34'sd25599744;
	localparam logic signed [ACC_W-1:0] SAT_MAX     = 34'sd2147483647;
	localparam logic signed [ACC_W-1:0] SAT_MIN     = -34'sd2147483648;

	// configuration register indexes (8-byte address stride)
	localparam logic [2:0] REG_START_BEGIN  = 3'd0;
	localparam logic [2:0] REG_START_SINGLE = 3'd3;
	localparam logic [2:0] REG_TRANS_BEGIN  = 3'd4;
	localparam logic [2:0] REG_TRANS_SINGLE = 3'd7;

	// configuration seen by the datapath
	typedef struct packed {
		logic [NSTATE-1:0][15:0] start;
		logic [NSTATE-1:0][63:0] trans;
	} vft_cfg_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ACS,
		ST_COMMIT,
		ST_PICK,
		ST_BT_RD,
		ST_BT_STEP,
		ST_OUT_RD,
		ST_OUT
	} vft_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       ld_in;
		logic       init;
		logic       set_ovf;
		logic       acs;
		logic [1:0] acs_idx;
		logic       commit;
		logic       pick;
		logic       bt_rd;
		logic       bt_step;
		logic       out_rd;
		logic       out_next;
	} vft_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic first;
		logic last;
		logic open;
		logic full;
		logic bt_zero;
		logic out_last;
	} vft_sts_t;

endpackage

FILE: src/vft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: src/vft_regs.sv
// APB-style configuration registers: start and transition scores.
// Depends on vft_pkg.
module vft_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	output vft_pkg::vft_cfg_t  cfg
);
	import vft_pkg::*;

	logic [2:0]  widx;
	logic        wr_en;
	vft_cfg_t    cfg_q;

	assign pready = 1'b1;
	assign widx   = paddr[5:3];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (widx) inside
				[REG_START_BEGIN:REG_START_SINGLE]: begin
					cfg_q.start[widx[1:0]] <= pwdata[15:0];
				end
				[REG_TRANS_BEGIN:REG_TRANS_SINGLE]: begin
					cfg_q.trans[widx[1:0]] <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		case (widx) inside
			[REG_START_BEGIN:REG_START_SINGLE]: prdata = 64'(cfg_q.start[widx[1:0]]);
			[REG_TRANS_BEGIN:REG_TRANS_SINGLE]: prdata = cfg_q.trans[widx[1:0]];
			default:                            prdata = '0;
		endcase
	end
endmodule

FILE: src/vft_ctrl.sv
// Sequencer of the tagger: forward step, backtrace and tag output.
// Depends on vft_pkg.
module vft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  vft_pkg::vft_sts_t sts,
	output vft_pkg::vft_cmd_t cmd
);
	import vft_pkg::*;

	vft_state_t state_q, state_d;
	logic [1:0] acs_cnt_q;

	// state register and target-state counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			acs_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACS) begin
				acs_cnt_q <= acs_cnt_q + 2'd1;
			end else begin
				acs_cnt_q <= '0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.acs_idx = acs_cnt_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.open) begin
					cmd.init = 1'b1;
					state_d  = sts.last ? ST_PICK : ST_IDLE;
				end else if (sts.full) begin
					cmd.set_ovf = 1'b1;
					state_d     = sts.last ? ST_PICK : ST_IDLE;
				end else begin
					state_d = ST_ACS;
				end
			end
			ST_ACS: begin
				cmd.acs = 1'b1;
				if (acs_cnt_q == 2'd3) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = sts.last ? ST_PICK : ST_IDLE;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_BT_RD;
			end
			ST_BT_RD: begin
				if (sts.bt_zero) begin
					state_d = ST_OUT_RD;
				end else begin
					cmd.bt_rd = 1'b1;
					state_d   = ST_BT_STEP;
				end
			end
			ST_BT_STEP: begin
				cmd.bt_step = 1'b1;
				state_d     = ST_BT_RD;
			end
			ST_OUT_RD: begin
				cmd.out_rd = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.out_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

FILE: src/vft_dp.sv
// Datapath of the tagger: path scores, add-compare-select unit,
// backpointer and tag memories. Depends on vft_pkg and vft_ram.
module vft_dp #(
	parameter int MAX_LEN     = vft_pkg::MAX_LEN_DEF,
	parameter int SCORE_WIDTH = vft_pkg::SCORE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vft_pkg::vft_cmd_t cmd,
	output vft_pkg::vft_sts_t sts,
	input  vft_pkg::vft_cfg_t cfg,
	input  logic [63:0]       in_data,
	input  logic              in_first,
	input  logic              in_last,
	output logic [39:0]       out_data,
	output logic              out_trunc,
	output logic              out_last
);
	import vft_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int OW = (SCORE_WIDTH < 16) ? SCORE_WIDTH : 16;

	// operand as signed OW-bit value, widened to the sum width
	function automatic logic signed [ACC_W-1:0] sext_op(input logic [15:0] v);
		logic signed [OW-1:0] t;
		t = v[OW-1:0];
		return ACC_W'(t);
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [SCORE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [SCORE_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[SCORE_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[SCORE_W-1:0];
		end else begin
			r = v[SCORE_W-1:0];
		end
		return r;
	endfunction

	// input word and sentence state
	logic [15:0]               emit_q [NSTATE];
	logic                      first_q, last_q;
	logic signed [SCORE_W-1:0] path_q [NSTATE];
	logic signed [SCORE_W-1:0] nxt_q  [NSTATE];
	logic [7:0]                bp_q;
	logic [CW-1:0]             count_q;
	logic                      ovf_q;
	// backtrace and output state
	logic [1:0]                tcur_q;
	logic signed [SCORE_W-1:0] bscore_q;
	logic [AW-1:0]             lastidx_q, bt_idx_q, out_idx_q;

	// add-compare-select signals
	logic signed [ACC_W-1:0]   e_sel;
	logic signed [ACC_W-1:0]   cand [NSTATE];
	logic signed [ACC_W-1:0]   acs_best;
	logic [1:0]                acs_pred;
	// final state choice
	logic [1:0]                pick_st;
	logic signed [SCORE_W-1:0] pick_val;
	logic [CW-1:0]             cnt_m1;
	// memory ports
	logic [7:0]                bp_rdata;
	logic                      tag_we;
	logic [AW-1:0]             tag_waddr;
	logic [1:0]                tag_wdata, tag_rdata, bt_tag;

	assign cnt_m1 = count_q - CW'(1);
	assign bt_tag = bp_rdata[2*tcur_q +: 2];

	// candidates for one target state, best over predecessors
	always_comb begin
		e_sel    = sext_op(emit_q[cmd.acs_idx]);
		acs_best = SCORE_FLOOR;
		acs_pred = '0;
		for (int k = 0; k < NSTATE; k++) begin
			cand[k] = ACC_W'(path_q[k]) + sext_op(cfg.trans[k][16*cmd.acs_idx +: 16]) + e_sel;
		end
		for (int k = 0; k < NSTATE; k++) begin
			if (cand[k] > acs_best) begin
				acs_best = cand[k];
				acs_pred = 2'(k);
			end
		end
	end

	// best final state, lowest index on ties
	always_comb begin
		pick_st  = '0;
		pick_val = path_q[0];
		for (int j = 1; j < NSTATE; j++) begin
			if (path_q[j] > pick_val) begin
				pick_val = path_q[j];
				pick_st  = 2'(j);
			end
		end
	end

	// input word and score registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			for (int j = 0; j < NSTATE; j++) begin
				emit_q[j] <= in_data[16*j +: 16];
			end
			first_q <= in_first;
			last_q  <= in_last;
		end
		if (cmd.init) begin
			for (int j = 0; j < NSTATE; j++) begin
				path_q[j] <= sat32(sext_op(cfg.start[j]) + sext_op(emit_q[j]));
			end
		end
		if (cmd.acs) begin
			nxt_q[cmd.acs_idx]       <= sat32(acs_best);
			bp_q[2*cmd.acs_idx +: 2] <= acs_pred;
		end
		if (cmd.commit) begin
			for (int j = 0; j < NSTATE; j++) begin
				path_q[j] <= nxt_q[j];
			end
		end
		if (cmd.pick) begin
			bscore_q <= pick_val;
		end
	end

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			tcur_q    <= '0;
			lastidx_q <= '0;
			bt_idx_q  <= '0;
			out_idx_q <= '0;
		end else begin
			if (cmd.init) begin
				count_q <= CW'(1);
				ovf_q   <= 1'b0;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.commit) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.pick) begin
				tcur_q    <= pick_st;
				lastidx_q <= cnt_m1[AW-1:0];
				bt_idx_q  <= cnt_m1[AW-1:0];
				out_idx_q <= '0;
				count_q   <= '0;
			end
			if (cmd.bt_step) begin
				tcur_q   <= bt_tag;
				bt_idx_q <= bt_idx_q - AW'(1);
			end
			if (cmd.out_next) begin
				out_idx_q <= out_idx_q + AW'(1);
			end
		end
	end

	// tag store: final state first, then one per backtrace step
	always_comb begin
		tag_we    = cmd.pick | cmd.bt_step;
		tag_waddr = cmd.pick ? cnt_m1[AW-1:0] : bt_idx_q - AW'(1);
		tag_wdata = cmd.pick ? pick_st : bt_tag;
	end

	vft_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LEN)
	) u_bp_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (count_q[AW-1:0]),
		.wdata (bp_q),
		.re    (cmd.bt_rd),
		.raddr (bt_idx_q),
		.rdata (bp_rdata)
	);

	vft_ram #(
		.WIDTH (2),
		.DEPTH (MAX_LEN)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.re    (cmd.out_rd),
		.raddr (out_idx_q),
		.rdata (tag_rdata)
	);

	// status to the controller
	always_comb begin
		sts.first    = first_q;
		sts.last     = last_q;
		sts.open     = first_q | (count_q == '0);
		sts.full     = (count_q >= CW'(MAX_LEN));
		sts.bt_zero  = (bt_idx_q == '0);
		sts.out_last = (out_idx_q == lastidx_q);
	end

	// output word
	assign out_data  = {bscore_q, 6'(out_idx_q), tag_rdata};
	assign out_trunc = ovf_q;
	assign out_last  = (out_idx_q == lastidx_q);
endmodule

FILE: src/viterbi_four_state_tagger_top.sv
// Four-state Viterbi tagger. A first or dropped character passes through accept and dispatch, every later one
// through accept, dispatch, one add-compare-select step per target state and commit.
// A last character adds the final pick, a read and a step through the backpointer RAM per backtrace
// step plus a read to end the walk, then a read and an output per tag word while the output is ready.
// Reset (async, active low) clears the configuration registers, counters, flags and the controller;
// the score registers are not reset, and the memories need no clearing.
module viterbi_four_state_tagger_top #(
	parameter int MAX_LEN     = vft_pkg::MAX_LEN_DEF,
	parameter int SCORE_WIDTH = vft_pkg::SCORE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // emit_begin, emit_end, emit_middle, emit_single
	input  logic        s_tuser,   // first_char
	input  logic        s_tlast,   // last_char
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // tag[1:0], char_position[7:2], best_score[39:8]
	output logic        m_tuser,   // truncated
	output logic        m_tlast,   // last_tag
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import vft_pkg::*;

	vft_cfg_t cfg;
	vft_cmd_t cmd;
	vft_sts_t sts;

	vft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vft_dp #(
		.MAX_LEN     (MAX_LEN),
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg),
		.in_data   (s_tdata),
		.in_first  (s_tuser),
		.in_last   (s_tlast),
		.out_data  (m_tdata),
		.out_trunc (m_tuser),
		.out_last  (m_tlast)
	);
endmodule

FILE: dv/tb.sv
// Self-checking bench for viterbi_four_state_tagger_top: directed table, then random
// sentences under several score settings, each word checked against an in-bench decoder.
// Depends on the RTL in src/ only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHARS = 64;
	localparam int SETTLE_CYCLES = 32;
	localparam int LIMIT_CYCLES = 400000;
	localparam longint SCORE_FLOOR_Q88 = -64'sd25599744;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef enum logic [1:0] {TAG_BEGIN, TAG_END, TAG_MIDDLE, TAG_SINGLE} tag_e;
	typedef enum logic [2:0] {
		R_START_BEGIN, R_START_END, R_START_MIDDLE, R_START_SINGLE,
		R_TRANS_BEGIN, R_TRANS_END, R_TRANS_MIDDLE, R_TRANS_SINGLE
	} cfg_reg_e;

	// one character word; emit[0] is the begin score
	typedef struct packed {
		logic             last;
		logic             first;
		logic [3:0][15:0] emit;
	} char_word_t;

	typedef struct packed {
		logic [1:0]         tag;
		logic [5:0]         pos;
		logic signed [31:0] score;
		logic               trunc;
		logic               last;
	} tag_word_t;

	typedef struct {
		logic [15:0] eb, ee, em, es;
		bit          first, last, known;
		tag_e        tag;
		int          score;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // emit_begin, emit_end, emit_middle, emit_single
	logic        s_tuser = 1'b0; // first_char
	logic        s_tlast = 1'b0; // last_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // tag[1:0], char_position[7:2], best_score[39:8]
	logic        m_tuser;        // truncated
	logic        m_tlast;        // last_tag
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	viterbi_four_state_tagger_top uut (.*);

	always #2 clk = ~clk;

	// decoder copy: score settings, path scores, backpointers
	logic [15:0] cfg_start [4] = '{default: '0};
	logic [63:0] cfg_trans [4] = '{default: '0};
	int          path_score [4] = '{default: 0};
	logic [7:0]  back_ptr [MAX_CHARS];
	int unsigned stored_chars = 0;
	bit          dropped_flag = 1'b0;

	tag_word_t   expected_tags [$];
	int          err_count = 0;
	int          cycle_count = 0;
	bit          tx_gaps_on = 1'b0;
	bit          rx_stall_on = 1'b0;
	int          rx_hold = 0;
	dir_row_t    dir_rows [13];

	function automatic longint sx16(logic [15:0] v);
		longint r;
		r = $signed(v);
		return r;
	endfunction

	function automatic int sat32(longint v);
		if (v > Q_MAX) return int'(Q_MAX);
		if (v < Q_MIN) return int'(Q_MIN);
		return int'(v);
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] rand_score();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// forward add-compare-select; on the last char, backtrace and queue the tags
	function automatic void decode_char(char_word_t w);
		longint      cand, best;
		int          next_score [4];
		logic [7:0]  bp;
		logic [1:0]  pred, final_state;
		logic [1:0]  tags [MAX_CHARS];
		int unsigned n;
		tag_word_t   t;
		if (w.first || stored_chars == 0) begin
			dropped_flag = 1'b0;
			for (int j = 0; j < 4; j++)
				path_score[j] = sat32(sx16(cfg_start[j]) + sx16(w.emit[j]));
			stored_chars = 1;
		end else if (stored_chars >= MAX_CHARS) begin
			dropped_flag = 1'b1;
		end else begin
			bp = '0;
			for (int j = 0; j < 4; j++) begin
				best = SCORE_FLOOR_Q88;
				pred = '0;
				// strict compare: lowest predecessor wins ties
				for (int k = 0; k < 4; k++) begin
					cand = longint'(path_score[k]) + sx16(cfg_trans[k][16*j +: 16])
						+ sx16(w.emit[j]);
					if (cand > best) begin
						best = cand;
						pred = 2'(k);
					end
				end
				next_score[j] = sat32(best);
				bp[2*j +: 2] = pred;
			end
			path_score = next_score;
			back_ptr[stored_chars] = bp;
			stored_chars++;
		end
		if (w.last) begin
			n = stored_chars;
			final_state = '0;
			for (int j = 1; j < 4; j++)
				if (path_score[j] > path_score[final_state])
					final_state = 2'(j);
			tags[n-1] = final_state;
			for (int i = n - 1; i > 0; i--)
				tags[i-1] = back_ptr[i][2*tags[i] +: 2];
			for (int i = 0; i < n; i++) begin
				t.tag = tags[i];
				t.pos = 6'(i);
				t.score = path_score[final_state];
				t.trunc = dropped_flag;
				t.last = (i == n - 1);
				expected_tags.push_back(t);
			end
			stored_chars = 0;
		end
	endfunction

	// offer one word, wait for the handshake, then predict
	task automatic push_char(char_word_t w);
		s_tdata <= w.emit;
		s_tuser <= w.first;
		s_tlast <= w.last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_char(w);
	endtask

	task automatic tx_gap();
		if (tx_gaps_on && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	task automatic send_sentence(int unsigned len, bit mark_first, bit mark_last, bit noisy);
		char_word_t w;
		for (int i = 0; i < len; i++) begin
			for (int j = 0; j < 4; j++)
				w.emit[j] = rand_score();
			w.first = (i == 0) ? mark_first : (noisy && $urandom_range(0, 19) == 0);
			w.last = (i == len - 1) && mark_last;
			push_char(w);
			tx_gap();
		end
	endtask

	// mostly well-formed sentences; some lack a first mark or are abandoned
	task automatic run_sentences(int unsigned n_items);
		int unsigned sent, len;
		bit closed;
		sent = 0;
		closed = 1'b1;
		while (sent < n_items) begin
			if ($urandom_range(0, 5) == 0) tx_gaps_on = !tx_gaps_on;
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			closed = ($urandom_range(0, 9) != 0);
			send_sentence(len, $urandom_range(0, 9) != 0, closed, 1'b1);
			sent += len;
		end
		if (!closed) send_sentence(1, 1'b0, 1'b1, 1'b0);
	endtask

	// hold off until every tag word is in, optionally letting the block settle
	task automatic drain(bit settle);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_tags.size() != 0);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(cfg_reg_e idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// write every register from the decoder copy; start regs get junk above bit 15
	task automatic apply_config();
		for (int i = 0; i < 4; i++)
			reg_write(cfg_reg_e'(i), {16'($urandom), 32'($urandom), cfg_start[i]});
		for (int i = 0; i < 4; i++)
			reg_write(cfg_reg_e'(i + 4), cfg_trans[i]);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic fill_config(logic [15:0] st, logic [15:0] tr, bit rnd);
		for (int i = 0; i < 4; i++) begin
			cfg_start[i] = rnd ? rand_score() : st;
			for (int j = 0; j < 4; j++)
				cfg_trans[i][16*j +: 16] = rnd ? rand_score() : tr;
		end
	endtask

	task automatic note_mismatch(string what, tag_word_t want, tag_word_t got);
		err_count++;
		if (err_count <= 10)
			$display("%s: tag %0d/%0d pos %0d/%0d score %0d/%0d trunc %0d/%0d last %0d/%0d",
				what, want.tag, got.tag, want.pos, got.pos, want.score, got.score,
				want.trunc, got.trunc, want.last, got.last);
	endtask

	// receiver: stretches of random stalls, stretches always ready
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) rx_stall_on = !rx_stall_on;
		if (rx_hold == 0 && rx_stall_on && $urandom_range(0, 3) == 0)
			rx_hold = pick_gap();
		if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// tag word check, oldest expectation first (expected/actual)
	always @(posedge clk) begin : tag_check
		tag_word_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.tag = m_tdata[1:0];
			got.pos = m_tdata[7:2];
			got.score = m_tdata[39:8];
			got.trunc = m_tuser;
			got.last = m_tlast;
			if (expected_tags.size() == 0) begin
				note_mismatch("unexpected word", '0, got);
			end else begin
				want = expected_tags.pop_front();
				if (got.tag !== want.tag || got.pos !== want.pos || got.score !== want.score
						|| got.trunc !== want.trunc || got.last !== want.last)
					note_mismatch("mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("viterbi_four_state_tagger_top regression: fail");
			$finish;
		end
	end

	initial begin
		char_word_t w;
		// zero settings after reset; known rows are one-char sentences
		dir_rows = '{
			'{16'h0064, 16'h00c8, 16'h012c, 16'h0190, 0, 0, 0, TAG_BEGIN, 0},
			'{16'hff9c, 16'h0032, 16'h8000, 16'h7fff, 0, 1, 0, TAG_BEGIN, 0},
			'{16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1, 1, 1, TAG_BEGIN, 32767},
			'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 1, 1, TAG_BEGIN, -32768},
			'{16'h0000, 16'h0000, 16'h0000, 16'h7fff, 1, 1, 1, TAG_SINGLE, 32767},
			'{16'hff00, 16'h0100, 16'hff00, 16'hff00, 0, 1, 1, TAG_END, 256},
			'{16'h0100, 16'hff00, 16'h0080, 16'hff80, 1, 0, 0, TAG_BEGIN, 0},
			'{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 0, 0, 0, TAG_BEGIN, 0},
			'{16'h0010, 16'h0020, 16'h0030, 16'h0040, 1, 0, 0, TAG_BEGIN, 0},
			'{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0, TAG_BEGIN, 0},
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, TAG_BEGIN, 0},
			'{16'h1111, 16'h2222, 16'hffff, 16'h0001, 0, 1, 0, TAG_BEGIN, 0},
			'{16'h0000, 16'h1234, 16'h1234, 16'h0000, 1, 1, 1, TAG_END, 4660}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		foreach (dir_rows[r]) begin
			w.emit = {dir_rows[r].es, dir_rows[r].em, dir_rows[r].ee, dir_rows[r].eb};
			w.first = dir_rows[r].first;
			w.last = dir_rows[r].last;
			push_char(w);
			if (dir_rows[r].known)
				expected_tags[expected_tags.size()-1] = '{dir_rows[r].tag, 6'd0,
					dir_rows[r].score, 1'b0, 1'b1};
			tx_gap();
		end
		drain(1'b1);

		// all scores at the top, then all at the bottom
		fill_config(16'h7fff, 16'h7fff, 1'b0);
		apply_config();
		run_sentences(20);
		drain(1'b1);
		fill_config(16'h8000, 16'h8000, 1'b0);
		apply_config();
		run_sentences(20);
		drain(1'b1);

		// random settings; overlong sentence ending on a dropped char
		fill_config('0, '0, 1'b1);
		apply_config();
		send_sentence(66, 1'b1, 1'b1, 1'b0);
		drain(1'b0);
		run_sentences(20);
		drain(1'b1);
		fill_config('0, '0, 1'b1);
		apply_config();
		run_sentences(20);
		drain(1'b1);

		if (err_count == 0)
			$display("viterbi_four_state_tagger_top regression: pass");
		else
			$display("viterbi_four_state_tagger_top regression: fail");
		$finish;
	end
endmodule
